FILE: sv/aoqt_pkg.sv
// Shared types, constants and rounding functions for the box overlap query table.
package aoqt_pkg;

   localparam int INDEX_W = 6;
   localparam int COUNT_W = 7;
   localparam int COORD_W = 16;
   localparam int FIXED_W = 32;
   localparam int FRAC_W  = 8;

   localparam logic signed [COORD_W-1:0] COORD_LO = -16'sd32768;
   localparam logic signed [COORD_W-1:0] COORD_HI = 16'sh7fff;

   typedef enum logic [1:0] {
      OP_SET       = 2'd0,
      OP_CLEAR     = 2'd1,
      OP_CLEAR_ALL = 2'd2,
      OP_QUERY     = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINAL
   } state_type;

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef struct packed {
      coord_type min_x;
      coord_type min_y;
      coord_type min_z;
      coord_type max_x;
      coord_type max_y;
      coord_type max_z;
   } box_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic step;
      logic emit_final;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic query_req;
      logic scan_end;
      logic stall;
      logic out_free;
   } status_type;

   function automatic coord_type sat16(input logic signed [FIXED_W:0] v);
      coord_type r;
      if (v > (FIXED_W+1)'(COORD_HI)) begin
         r = COORD_HI;
      end else if (v < (FIXED_W+1)'(COORD_LO)) begin
         r = COORD_LO;
      end else begin
         r = v[COORD_W-1:0];
      end
      return r;
   endfunction

   function automatic coord_type floor_q8(input logic signed [FIXED_W-1:0] v);
      logic signed [FIXED_W:0] w;
      w = (FIXED_W+1)'(v);
      return sat16(w >>> FRAC_W);
   endfunction

   function automatic coord_type ceil_q8(input logic signed [FIXED_W-1:0] v);
      logic signed [FIXED_W:0] w;
      w = (FIXED_W+1)'(v) + (FIXED_W+1)'((1 << FRAC_W) - 1);
      return sat16(w >>> FRAC_W);
   endfunction

   // inclusive overlap on all three axes
   function automatic logic overlaps(input box_type q, input box_type e);
      return (q.min_x <= e.max_x) && (e.min_x <= q.max_x) &&
             (q.min_y <= e.max_y) && (e.min_y <= q.max_y) &&
             (q.min_z <= e.max_z) && (e.min_z <= q.max_z);
   endfunction

endpackage

FILE: sv/aoqt_if.sv
// Request and response channel interfaces of the box overlap query table.
interface aoqt_req_if;
   logic                                   valid;
   logic                                   ready;
   logic [1:0]                             opcode;
   logic [aoqt_pkg::INDEX_W-1:0]           index;
   logic signed [aoqt_pkg::FIXED_W-1:0]    min_x;
   logic signed [aoqt_pkg::FIXED_W-1:0]    min_y;
   logic signed [aoqt_pkg::FIXED_W-1:0]    min_z;
   logic signed [aoqt_pkg::FIXED_W-1:0]    max_x;
   logic signed [aoqt_pkg::FIXED_W-1:0]    max_y;
   logic signed [aoqt_pkg::FIXED_W-1:0]    max_z;

   modport source (output valid, opcode, index, min_x, min_y, min_z, max_x, max_y, max_z,
                   input ready);
   modport sink (input valid, opcode, index, min_x, min_y, min_z, max_x, max_y, max_z,
                 output ready);
endinterface

interface aoqt_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         hit_valid;
   logic [aoqt_pkg::INDEX_W-1:0] hit_index;
   logic [aoqt_pkg::COUNT_W-1:0] hit_count;
   logic                         last;

   modport source (output valid, hit_valid, hit_index, hit_count, last, input ready);
   modport sink (input valid, hit_valid, hit_index, hit_count, last, output ready);
endinterface

FILE: sv/aabb_overlap_query_table.sv
// Top level of the 3D box overlap query table.
//
//   channel   dir  handshake      payload
//   req_ch    in   valid/ready    opcode, index, min_x..z, max_x..z (Q24.8)
//   rsp_ch    out  valid/ready    hit_valid, hit_index, hit_count, last
//
// A query holds the request side until its final response is issued: the table memory
// has one read port, so the scan reads and compares one stored box per cycle while no
// response stalls, then issues the final response.
// The scan holds while a new hit finds the response register still occupied.
// Reset clears all valid bits, the scan limit and the response register; box contents
// need no clearing since an entry counts as a hit only while its valid bit is set.
module aabb_overlap_query_table #(
   parameter int ENTRIES = 64
) (
   input  logic         clock,
   input  logic         reset,
   aoqt_req_if.sink     req_ch,
   aoqt_rsp_if.source   rsp_ch
);

   aoqt_pkg::cmd_type     cmd;
   aoqt_pkg::status_type  sts;

   aoqt_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .cmd   (cmd)
   );

   aoqt_dp #(
      .ENTRIES (ENTRIES)
   ) u_dp (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .cmd    (cmd),
      .sts    (sts)
   );

endmodule

FILE: sv/aoqt_ctrl.sv
// Controller state machine: sequences request intake, table scan and final response.
module aoqt_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  aoqt_pkg::status_type  sts,
   output aoqt_pkg::cmd_type     cmd
);

   aoqt_pkg::state_type state_ff;
   aoqt_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= aoqt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         aoqt_pkg::ST_IDLE: begin
            cmd.accept = 1'b1;
            if (sts.query_req) begin
               state_in = aoqt_pkg::ST_SCAN;
            end
         end
         aoqt_pkg::ST_SCAN: begin
            if (sts.scan_end) begin
               state_in = aoqt_pkg::ST_FINAL;
            end else begin
               // hold the scan while a second hit waits on a full response slot
               cmd.step = !sts.stall;
            end
         end
         aoqt_pkg::ST_FINAL: begin
            if (sts.out_free) begin
               cmd.emit_final = 1'b1;
               state_in       = aoqt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = aoqt_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

FILE: sv/aoqt_dp.sv
// Datapath: box table memory, valid bits, scan pipeline and response register.
module aoqt_dp #(
   parameter int ENTRIES = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   aoqt_req_if.sink              req_ch,
   aoqt_rsp_if.source            rsp_ch,
   input  aoqt_pkg::cmd_type     cmd,
   output aoqt_pkg::status_type  sts
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam logic [aoqt_pkg::INDEX_W:0] IDX_LIMIT = (aoqt_pkg::INDEX_W+1)'(ENTRIES);

   aoqt_pkg::box_type   table_mem [ENTRIES];
   logic [ENTRIES-1:0]  valid_ff;
   logic [CNT_W-1:0]    limit_ff;
   aoqt_pkg::box_type   query_ff;
   logic [CNT_W-1:0]    addr_ff;
   logic                s1_valid_ff;
   logic [IDX_W-1:0]    s1_idx_ff;
   aoqt_pkg::box_type   rd_data_ff;
   logic                pend_ff;
   logic [IDX_W-1:0]    pend_idx_ff;
   logic [CNT_W-1:0]    cnt_ff;

   logic                          rsp_valid_ff;
   logic                          hit_valid_ff;
   logic [aoqt_pkg::INDEX_W-1:0]  hit_index_ff;
   logic [aoqt_pkg::COUNT_W-1:0]  hit_count_ff;
   logic                          last_ff;

   aoqt_pkg::box_type  box_in;
   aoqt_pkg::op_type   op;
   logic               take;
   logic               idx_ok;
   logic [IDX_W-1:0]   widx;
   logic [CNT_W-1:0]   new_limit;
   logic               more;
   logic               s1_hit;
   logic               out_free;
   logic               emit_pend;
   logic               load_out;

   assign op     = aoqt_pkg::op_type'(req_ch.opcode);
   assign take   = cmd.accept && req_ch.valid;
   assign idx_ok = {1'b0, req_ch.index} < IDX_LIMIT;
   assign widx   = req_ch.index[IDX_W-1:0];
   assign new_limit = CNT_W'(widx) + CNT_W'(1);

   always_comb begin
      box_in.min_x = aoqt_pkg::floor_q8(req_ch.min_x);
      box_in.min_y = aoqt_pkg::floor_q8(req_ch.min_y);
      box_in.min_z = aoqt_pkg::floor_q8(req_ch.min_z);
      box_in.max_x = aoqt_pkg::ceil_q8(req_ch.max_x);
      box_in.max_y = aoqt_pkg::ceil_q8(req_ch.max_y);
      box_in.max_z = aoqt_pkg::ceil_q8(req_ch.max_z);
   end

   assign more      = addr_ff < limit_ff;
   assign s1_hit    = s1_valid_ff && valid_ff[s1_idx_ff] &&
                      aoqt_pkg::overlaps(query_ff, rd_data_ff);
   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign emit_pend = cmd.step && s1_hit && pend_ff;
   assign load_out  = emit_pend || cmd.emit_final;

   assign sts.query_req = req_ch.valid && (op == aoqt_pkg::OP_QUERY);
   assign sts.scan_end  = !more && !s1_valid_ff;
   assign sts.stall     = s1_hit && pend_ff && !out_free;
   assign sts.out_free  = out_free;

   // table memory: write on set, one read per scan step
   always_ff @(posedge clock) begin
      if (take && op == aoqt_pkg::OP_SET && idx_ok) begin
         table_mem[widx] <= box_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step && more) begin
         rd_data_ff <= table_mem[addr_ff[IDX_W-1:0]];
      end
   end

   // valid bits and scan limit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         limit_ff <= '0;
      end else if (take) begin
         unique case (op)
            aoqt_pkg::OP_SET: begin
               if (idx_ok) begin
                  valid_ff[widx] <= 1'b1;
                  if (new_limit > limit_ff) begin
                     limit_ff <= new_limit;
                  end
               end
            end
            aoqt_pkg::OP_CLEAR: begin
               if (idx_ok) begin
                  valid_ff[widx] <= 1'b0;
               end
            end
            aoqt_pkg::OP_CLEAR_ALL: begin
               valid_ff <= '0;
               limit_ff <= '0;
            end
            aoqt_pkg::OP_QUERY: begin
               valid_ff <= valid_ff;
            end
            default: begin
               valid_ff <= valid_ff;
            end
         endcase
      end
   end

   // scan pipeline: read stage, then compare stage with one pending hit
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         pend_ff     <= 1'b0;
      end else if (take && op == aoqt_pkg::OP_QUERY) begin
         query_ff    <= box_in;
         addr_ff     <= '0;
         cnt_ff      <= '0;
         s1_valid_ff <= 1'b0;
         pend_ff     <= 1'b0;
      end else if (cmd.step) begin
         s1_valid_ff <= more;
         if (more) begin
            s1_idx_ff <= addr_ff[IDX_W-1:0];
            addr_ff   <= addr_ff + CNT_W'(1);
         end
         if (s1_hit) begin
            pend_ff     <= 1'b1;
            pend_idx_ff <= s1_idx_ff;
            cnt_ff      <= cnt_ff + CNT_W'(1);
         end
      end else if (cmd.emit_final) begin
         pend_ff <= 1'b0;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         hit_valid_ff <= pend_ff;
         hit_index_ff <= pend_ff ? aoqt_pkg::INDEX_W'(pend_idx_ff) : '0;
         hit_count_ff <= aoqt_pkg::COUNT_W'(cnt_ff);
         last_ff      <= cmd.emit_final;
      end
   end

   assign req_ch.ready     = cmd.accept;
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.hit_valid = hit_valid_ff;
   assign rsp_ch.hit_index = hit_index_ff;
   assign rsp_ch.hit_count = hit_count_ff;
   assign rsp_ch.last      = last_ff;

endmodule

FILE: tb/tb_aabb_overlap_query_table.sv
// Self-checking testbench for the 3D box overlap query table: directed and random requests.
`timescale 1ns / 100ps

module tb_aabb_overlap_query_table;

   localparam int ENTRIES      = 64;
   localparam int IDLE_MAX     = 11;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = ENTRIES + 16;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int MAX_REPORTS  = 10;
   localparam int INDEX_W      = aoqt_pkg::INDEX_W;
   localparam int COUNT_W      = aoqt_pkg::COUNT_W;
   localparam int FIXED_W      = aoqt_pkg::FIXED_W;
   localparam int FRAC_W       = aoqt_pkg::FRAC_W;
   localparam logic signed [FIXED_W-1:0] RAW_MIN = 32'sh8000_0000;
   localparam logic signed [FIXED_W-1:0] RAW_MAX = 32'sh7fff_ffff;
   localparam int UNIT = 1 << FRAC_W;

   typedef struct packed {
      aoqt_pkg::op_type          op;
      logic [INDEX_W-1:0]        index;
      logic signed [FIXED_W-1:0] min_x;
      logic signed [FIXED_W-1:0] min_y;
      logic signed [FIXED_W-1:0] min_z;
      logic signed [FIXED_W-1:0] max_x;
      logic signed [FIXED_W-1:0] max_y;
      logic signed [FIXED_W-1:0] max_z;
   } box_request_type;

   typedef struct packed {
      logic               hit_valid;
      logic [INDEX_W-1:0] hit_index;
      logic [COUNT_W-1:0] hit_count;
      logic               last;
   } hit_result_type;

   class hit_scoreboard;
      aoqt_pkg::box_type entry_box[ENTRIES];
      bit [ENTRIES-1:0]  entry_live;
      int                scan_limit_q;
      hit_result_type    pending_hits[$];
      int                mismatches;

      function new();
         entry_live   = '0;
         scan_limit_q = 0;
         mismatches   = 0;
      endfunction

      static function aoqt_pkg::coord_type clamp16(longint v);
         if (v > longint'(aoqt_pkg::COORD_HI)) return aoqt_pkg::COORD_HI;
         if (v < longint'(aoqt_pkg::COORD_LO)) return aoqt_pkg::COORD_LO;
         return aoqt_pkg::coord_type'(v);
      endfunction

      static function aoqt_pkg::coord_type round_down(logic signed [FIXED_W-1:0] raw);
         longint v;
         v = raw;
         return clamp16(v >>> FRAC_W);
      endfunction

      // bias by one less than a whole unit, then floor
      static function aoqt_pkg::coord_type round_up(logic signed [FIXED_W-1:0] raw);
         longint v;
         v = raw;
         v = v + UNIT - 1;
         return clamp16(v >>> FRAC_W);
      endfunction

      static function aoqt_pkg::box_type round_box(box_request_type r);
         aoqt_pkg::box_type b;
         b.min_x = round_down(r.min_x);
         b.min_y = round_down(r.min_y);
         b.min_z = round_down(r.min_z);
         b.max_x = round_up(r.max_x);
         b.max_y = round_up(r.max_y);
         b.max_z = round_up(r.max_z);
         return b;
      endfunction

      // a gap on any one axis separates the boxes
      static function bit boxes_touch(aoqt_pkg::box_type a, aoqt_pkg::box_type b);
         if ($signed(a.min_x) > $signed(b.max_x) || $signed(b.min_x) > $signed(a.max_x))
            return 1'b0;
         if ($signed(a.min_y) > $signed(b.max_y) || $signed(b.min_y) > $signed(a.max_y))
            return 1'b0;
         if ($signed(a.min_z) > $signed(b.max_z) || $signed(b.min_z) > $signed(a.max_z))
            return 1'b0;
         return 1'b1;
      endfunction

      function void note_request(box_request_type r);
         aoqt_pkg::box_type q;
         int                hits;
         case (r.op)
            aoqt_pkg::OP_SET: begin
               entry_box[r.index]  = round_box(r);
               entry_live[r.index] = 1'b1;
               if (int'(r.index) + 1 > scan_limit_q) scan_limit_q = int'(r.index) + 1;
            end
            aoqt_pkg::OP_CLEAR: begin
               entry_live[r.index] = 1'b0;
            end
            aoqt_pkg::OP_CLEAR_ALL: begin
               entry_live   = '0;
               scan_limit_q = 0;
            end
            default: begin
               q    = round_box(r);
               hits = 0;
               for (int i = 0; i < scan_limit_q; i++) begin
                  if (entry_live[i] && boxes_touch(q, entry_box[i])) begin
                     hits++;
                     pending_hits.push_back('{hit_valid: 1'b1, hit_index: INDEX_W'(i),
                                              hit_count: COUNT_W'(hits), last: 1'b0});
                  end
               end
               if (hits == 0) begin
                  pending_hits.push_back('{hit_valid: 1'b0, hit_index: '0,
                                           hit_count: '0, last: 1'b1});
               end else begin
                  pending_hits[pending_hits.size() - 1].last = 1'b1;
               end
            end
         endcase
      endfunction

      function int pending();
         return pending_hits.size();
      endfunction

      function void check_hit(hit_result_type got);
         hit_result_type want;
         if (pending_hits.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: unexpected response valid=%0b index=%0d count=%0d last=%0b",
                        $time, got.hit_valid, got.hit_index, got.hit_count, got.last);
            return;
         end
         want = pending_hits.pop_front();
         if (got.hit_valid !== want.hit_valid || got.hit_index !== want.hit_index ||
             got.hit_count !== want.hit_count || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display({"%0t: response differs: expected valid=%0b index=%0d count=%0d ",
                         "last=%0b, got valid=%0b index=%0d count=%0d last=%0b"},
                        $time, want.hit_valid, want.hit_index, want.hit_count, want.last,
                        got.hit_valid, got.hit_index, got.hit_count, got.last);
         end
      endfunction
   endclass

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   bit            idle_on = 1'b1;
   int            hold_req = 0;
   int            hold_done = 0;
   int unsigned   cycle_count = 0;
   hit_scoreboard sb;

   aoqt_req_if req_ch();
   aoqt_rsp_if rsp_ch();

   aabb_overlap_query_table #(.ENTRIES(ENTRIES)) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // mostly a small window so boxes meet often, with wide and edge values mixed in
   function automatic logic signed [FIXED_W-1:0] rand_coord();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) return int'($urandom_range(0, 128 * UNIT)) - 64 * UNIT;
      if (pick < 85) return $urandom();
      if (pick < 95) return (int'($urandom_range(0, 128)) - 64) * UNIT;
      case ($urandom_range(0, 3))
         0:       return RAW_MIN;
         1:       return RAW_MAX;
         2:       return 0;
         default: return -1;
      endcase
   endfunction

   function automatic box_request_type random_box(aoqt_pkg::op_type op,
                                                  logic [INDEX_W-1:0] idx);
      box_request_type           r;
      logic signed [FIXED_W-1:0] lo[3];
      logic signed [FIXED_W-1:0] hi[3];
      for (int a = 0; a < 3; a++) begin
         lo[a] = rand_coord();
         if ($urandom_range(0, 9) == 0) hi[a] = rand_coord();
         else hi[a] = lo[a] + FIXED_W'($urandom_range(0, 40 * UNIT));
      end
      r.op    = op;
      r.index = idx;
      r.min_x = lo[0];
      r.min_y = lo[1];
      r.min_z = lo[2];
      r.max_x = hi[0];
      r.max_y = hi[1];
      r.max_z = hi[2];
      return r;
   endfunction

   function automatic box_request_type random_request();
      int               pick;
      aoqt_pkg::op_type op;
      pick = $urandom_range(0, 99);
      if (pick < 45) op = aoqt_pkg::OP_SET;
      else if (pick < 80) op = aoqt_pkg::OP_QUERY;
      else if (pick < 93) op = aoqt_pkg::OP_CLEAR;
      else op = aoqt_pkg::OP_CLEAR_ALL;
      return random_box(op, INDEX_W'($urandom_range(0, ENTRIES - 1)));
   endfunction

   function automatic box_request_type cube(aoqt_pkg::op_type op, int idx,
                                            logic signed [FIXED_W-1:0] lo,
                                            logic signed [FIXED_W-1:0] hi);
      box_request_type r;
      r.op    = op;
      r.index = INDEX_W'(idx);
      r.min_x = lo;
      r.min_y = lo;
      r.min_z = lo;
      r.max_x = hi;
      r.max_y = hi;
      r.max_z = hi;
      return r;
   endfunction

   // called and left at a falling edge; valid stays high when the next request follows at once
   task automatic send_request(box_request_type r);
      int gap;
      gap = idle_on ? $urandom_range(0, IDLE_MAX) : 0;
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid  = 1'b1;
      req_ch.opcode = r.op;
      req_ch.index  = r.index;
      req_ch.min_x  = r.min_x;
      req_ch.min_y  = r.min_y;
      req_ch.min_z  = r.min_z;
      req_ch.max_x  = r.max_x;
      req_ch.max_y  = r.max_y;
      req_ch.max_z  = r.max_z;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      sb.note_request(r);
      @(negedge clock);
   endtask

   task automatic drain_responses();
      req_ch.valid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // response side
   initial begin
      int             stall;
      hit_result_type got;
      rsp_ch.ready = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         if (hold_req != hold_done) begin
            rsp_ch.ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_done = hold_req;
         end
         stall = idle_on ? $urandom_range(0, IDLE_MAX) : 0;
         if (stall > 0) begin
            rsp_ch.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready = 1'b1;
         do @(posedge clock); while (rsp_ch.valid !== 1'b1);
         got.hit_valid = rsp_ch.hit_valid;
         got.hit_index = rsp_ch.hit_index;
         got.hit_count = rsp_ch.hit_count;
         got.last      = rsp_ch.last;
         sb.check_hit(got);
         @(negedge clock);
      end
   end

   initial begin
      sb = new();
      req_ch.valid  = 1'b0;
      req_ch.opcode = aoqt_pkg::OP_SET;
      req_ch.index  = '0;
      req_ch.min_x  = '0;
      req_ch.min_y  = '0;
      req_ch.min_z  = '0;
      req_ch.max_x  = '0;
      req_ch.max_y  = '0;
      req_ch.max_z  = '0;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // empty table right after reset: nothing to scan
      send_request(cube(aoqt_pkg::OP_QUERY, 0, RAW_MIN, RAW_MAX));
      send_request(cube(aoqt_pkg::OP_CLEAR_ALL, 0, 0, 0));

      send_request(cube(aoqt_pkg::OP_SET, 0, 0, 10 * UNIT));
      send_request(cube(aoqt_pkg::OP_SET, 1, -1, 1));
      send_request(cube(aoqt_pkg::OP_SET, 2, RAW_MIN, RAW_MAX));
      send_request(cube(aoqt_pkg::OP_SET, 63, 11 * UNIT, 20 * UNIT - 1));
      send_request(cube(aoqt_pkg::OP_SET, 5, 30 * UNIT, 20 * UNIT));
      send_request(cube(aoqt_pkg::OP_SET, 7, 32'sh7fff_ff00, RAW_MAX));
      send_request(cube(aoqt_pkg::OP_SET, 8, RAW_MIN, 32'sh8000_0001));
      // touching faces count as overlap
      send_request(cube(aoqt_pkg::OP_QUERY, 0, 10 * UNIT, 11 * UNIT));
      send_request(cube(aoqt_pkg::OP_QUERY, 0, RAW_MIN, RAW_MAX));
      send_request(cube(aoqt_pkg::OP_QUERY, 0, 100 * UNIT, -100 * UNIT));
      send_request(cube(aoqt_pkg::OP_QUERY, 0, -UNIT - 1, -1));
      send_request(cube(aoqt_pkg::OP_CLEAR, 2, 0, 0));
      send_request(cube(aoqt_pkg::OP_QUERY, 0, RAW_MIN, RAW_MAX));
      send_request(cube(aoqt_pkg::OP_CLEAR, 63, 0, 0));
      send_request(cube(aoqt_pkg::OP_QUERY, 0, 10 * UNIT, 11 * UNIT));
      send_request(cube(aoqt_pkg::OP_SET, 63, 11 * UNIT, 20 * UNIT - 1));
      send_request(cube(aoqt_pkg::OP_QUERY, 0, 15 * UNIT, 16 * UNIT));
      send_request(cube(aoqt_pkg::OP_CLEAR_ALL, 0, 0, 0));
      send_request(cube(aoqt_pkg::OP_QUERY, 0, RAW_MIN, RAW_MAX));
      send_request(cube(aoqt_pkg::OP_SET, 3, -5 * UNIT, 5 * UNIT));
      send_request(cube(aoqt_pkg::OP_QUERY, 0, RAW_MIN, RAW_MAX));
      drain_responses();

      for (int n = 0; n < 30; n++) send_request(random_request());
      drain_responses();

      idle_on = 1'b0;
      for (int n = 0; n < 25; n++) send_request(random_request());
      drain_responses();
      idle_on = 1'b1;

      // stall the response side so full-range queries back up into the request side
      hold_req++;
      for (int n = 0; n < 4; n++)
         send_request(random_box(aoqt_pkg::OP_SET, INDEX_W'($urandom_range(0, ENTRIES - 1))));
      for (int n = 0; n < 8; n++) send_request(cube(aoqt_pkg::OP_QUERY, 0, RAW_MIN, RAW_MAX));
      drain_responses();

      for (int n = 0; n < 20; n++) send_request(random_request());
      drain_responses();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
